[hdl/owm_pkg.sv]
// Package: shared types, codes and constants of the 1-Wire master timing block.
package owm_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int LEN_W           = 16;
  localparam int BYTE_W          = 8;
  localparam int NUM_REGS        = 7;
  localparam int REG_IDX_W       = 3;

  // Register reset values.
  localparam logic [LEN_W-1:0] RST_RESET_LOW  = 16'd600;
  localparam logic [LEN_W-1:0] RST_PRES_WAIT  = 16'd60;
  localparam logic [LEN_W-1:0] RST_SLOT_LOW   = 16'd2;
  localparam logic [LEN_W-1:0] RST_WRITE_HOLD = 16'd60;
  localparam logic [LEN_W-1:0] RST_WRITE_REC  = 16'd10;
  localparam logic [LEN_W-1:0] RST_READ_REL   = 16'd2;
  localparam logic [LEN_W-1:0] RST_READ_TAIL  = 16'd60;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESET_LOW  = 3'd0,
    REG_PRES_WAIT  = 3'd1,
    REG_SLOT_LOW   = 3'd2,
    REG_WRITE_HOLD = 3'd3,
    REG_WRITE_REC  = 3'd4,
    REG_READ_REL   = 3'd5,
    REG_READ_TAIL  = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_W_LOW    = 4'd4,
    PH_W_HOLD   = 4'd5,
    PH_W_REC    = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_REL    = 4'd8,
    PH_R_TAIL   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] reset_low;
    logic [LEN_W-1:0] pres_wait;
    logic [LEN_W-1:0] slot_low;
    logic [LEN_W-1:0] write_hold;
    logic [LEN_W-1:0] write_rec;
    logic [LEN_W-1:0] read_rel;
    logic [LEN_W-1:0] read_tail;
  } cfg_regs_t;

  typedef struct packed {
    logic              line_release;
    logic              busy_res;
    logic              done_res;
    logic              presence_absent;
    logic [BYTE_W-1:0] read_byte;
    logic              rejected;
  } result_t;

endpackage

[hdl/owm_if.sv]
// Interfaces: command/tick input channel, result channel and register write channel.
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] write_byte;
  logic       line_in;

  modport source (output valid, output op, output write_byte, output line_in, input ready);
  modport sink   (input valid, input op, input write_byte, input line_in, output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       line_release;
  logic       busy_res;
  logic       done_res;
  logic       presence_absent;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (output valid, output line_release, output busy_res, output done_res,
                  output presence_absent, output read_byte, output rejected, input ready);
  modport sink   (input valid, input line_release, input busy_res, input done_res,
                  input presence_absent, input read_byte, input rejected, output ready);
endinterface

interface owm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/one_wire_master_timing_top.sv]
// Top level: 1-Wire bus master timing block with input and result registers.
// Each transaction on the input channel is either a tick of the external delay
// unit (op 0) or a command: reset pulse with presence sampling (op 1), byte
// write sent LSB first (op 2) or byte read sampled LSB first (op 3). It also
// carries the sampled bus level. Every input transaction produces exactly one
// result transaction giving the line drive (1 = release), busy, done, the last
// presence sample, the shift register contents and a reject flag for a command
// that arrived while busy. The block takes one transaction per clock: an input
// register feeds a single-pass step of the timing state, whose result lands in
// an output register; while the result register is held by a stalled sink the
// input register still fills, so throughput is one transaction per cycle as long
// as the sink keeps up. Phase lengths are counted in ticks, held in seven 16-bit
// registers (index 0..6: reset low, presence wait, slot low, write hold, write
// recovery, read release, read tail); a zero length counts as one tick and a
// length above the timer range saturates to the largest TIMER_WIDTH count. Write
// registers only while idle; writes to index 7 are dropped.
module one_wire_master_timing_top #(
  parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  owm_in_if.sink  in_if,
  owm_out_if.source out_if,
  owm_cfg_if.sink cfg_if
);
  import owm_pkg::*;

  cfg_regs_t         regs;
  result_t           res;

  // input register
  logic              s1_v_r, s1_v_nxt;
  logic [1:0]        s1_op_r;
  logic [BYTE_W-1:0] s1_wb_r;
  logic              s1_lin_r;

  // result register
  logic              out_v_r, out_v_nxt;
  result_t           out_res_r;

  logic              in_acc;
  logic              adv;

  // configuration channel never stalls
  assign cfg_if.ready = 1'b1;

  owm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_if.valid),
    .wr_idx  (cfg_if.index),
    .wr_data (cfg_if.data),
    .regs    (regs)
  );

  // step fires when the input register holds an item and the result slot frees
  assign adv          = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !s1_v_r || adv;
  assign in_acc       = in_if.valid && in_if.ready;

  owm_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .op         (s1_op_r),
    .write_byte (s1_wb_r),
    .line_in    (s1_lin_r),
    .regs       (regs),
    .res        (res)
  );

  assign s1_v_nxt  = in_acc || (s1_v_r && !adv);
  assign out_v_nxt = adv || (out_v_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_if.op;
      s1_wb_r  <= in_if.write_byte;
      s1_lin_r <= in_if.line_in;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid           = out_v_r;
  assign out_if.line_release    = out_res_r.line_release;
  assign out_if.busy_res        = out_res_r.busy_res;
  assign out_if.done_res        = out_res_r.done_res;
  assign out_if.presence_absent = out_res_r.presence_absent;
  assign out_if.read_byte       = out_res_r.read_byte;
  assign out_if.rejected        = out_res_r.rejected;

endmodule

[hdl/owm_cfg_regs.sv]
// Phase length register file, written through the configuration channel.
module owm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [owm_pkg::REG_IDX_W-1:0]  wr_idx,
  input  logic [owm_pkg::LEN_W-1:0]      wr_data,
  output owm_pkg::cfg_regs_t             regs
);
  import owm_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_idx))
        REG_RESET_LOW:  regs_nxt.reset_low  = wr_data;
        REG_PRES_WAIT:  regs_nxt.pres_wait  = wr_data;
        REG_SLOT_LOW:   regs_nxt.slot_low   = wr_data;
        REG_WRITE_HOLD: regs_nxt.write_hold = wr_data;
        REG_WRITE_REC:  regs_nxt.write_rec  = wr_data;
        REG_READ_REL:   regs_nxt.read_rel   = wr_data;
        REG_READ_TAIL:  regs_nxt.read_tail  = wr_data;
        default:        regs_nxt = regs_r;  // index beyond the file: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.reset_low  <= RST_RESET_LOW;
      regs_r.pres_wait  <= RST_PRES_WAIT;
      regs_r.slot_low   <= RST_SLOT_LOW;
      regs_r.write_hold <= RST_WRITE_HOLD;
      regs_r.write_rec  <= RST_WRITE_REC;
      regs_r.read_rel   <= RST_READ_REL;
      regs_r.read_tail  <= RST_READ_TAIL;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

[hdl/owm_step.sv]
// Bus timing state and the single-pass step that advances it by one item.
module owm_step #(
  parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [1:0]                   op,
  input  logic [owm_pkg::BYTE_W-1:0]   write_byte,
  input  logic                         line_in,
  input  owm_pkg::cfg_regs_t           regs,
  output owm_pkg::result_t             res
);
  import owm_pkg::*;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  phase_t                   phase_r,  phase_nxt;
  logic [TIMER_WIDTH-1:0]   timer_r,  timer_nxt;
  logic [2:0]               bit_r,    bit_nxt;
  logic [BYTE_W-1:0]        shift_r,  shift_nxt;
  logic                     pres_r,   pres_nxt;
  logic                     line_r,   line_nxt;
  logic                     done;
  logic                     rej;
  logic [TIMER_WIDTH-1:0]   dec;

  // Zero counts as one tick; lengths beyond the timer saturate.
  function automatic logic [TIMER_WIDTH-1:0] load_len(input logic [LEN_W-1:0] v);
    logic [32:0] w;
    w = {17'd0, v};
    if (w == 33'd0) w = 33'd1;
    if (w > TMAX)   w = TMAX;
    return w[TIMER_WIDTH-1:0];
  endfunction

  assign dec = timer_r - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    line_nxt  = line_r;
    done      = 1'b0;
    rej       = 1'b0;

    unique case (op_t'(op))
      OP_TICK: begin
        if (phase_r == PH_RST_REC) begin
          // wait for the line to come back high after presence
          if (line_in) begin
            phase_nxt = PH_IDLE;
            line_nxt  = 1'b1;
            timer_nxt = '0;
            bit_nxt   = '0;
            done      = 1'b1;
          end
        end else if (phase_r != PH_IDLE) begin
          timer_nxt = dec;
          if (dec == '0) begin
            unique case (phase_r)
              PH_RST_LOW: begin
                phase_nxt = PH_RST_WAIT;
                line_nxt  = 1'b1;
                timer_nxt = load_len(regs.pres_wait);
              end
              PH_RST_WAIT: begin
                pres_nxt = line_in;
                line_nxt = 1'b1;
                if (line_in) begin
                  phase_nxt = PH_IDLE;
                  timer_nxt = '0;
                  bit_nxt   = '0;
                  done      = 1'b1;
                end else begin
                  phase_nxt = PH_RST_REC;
                  timer_nxt = '0;
                end
              end
              PH_W_LOW: begin
                phase_nxt = PH_W_HOLD;
                line_nxt  = shift_r[0];
                shift_nxt = shift_r >> 1;
                timer_nxt = load_len(regs.write_hold);
              end
              PH_W_HOLD: begin
                phase_nxt = PH_W_REC;
                line_nxt  = 1'b1;
                timer_nxt = load_len(regs.write_rec);
              end
              PH_W_REC: begin
                if (bit_r == 3'd7) begin
                  phase_nxt = PH_IDLE;
                  line_nxt  = 1'b1;
                  timer_nxt = '0;
                  bit_nxt   = '0;
                  done      = 1'b1;
                end else begin
                  phase_nxt = PH_W_LOW;
                  line_nxt  = 1'b0;
                  bit_nxt   = bit_r + 3'd1;
                  timer_nxt = load_len(regs.slot_low);
                end
              end
              PH_R_LOW: begin
                phase_nxt = PH_R_REL;
                line_nxt  = 1'b1;
                timer_nxt = load_len(regs.read_rel);
              end
              PH_R_REL: begin
                shift_nxt[bit_r] = shift_r[bit_r] | line_in;
                phase_nxt = PH_R_TAIL;
                line_nxt  = 1'b1;
                timer_nxt = load_len(regs.read_tail);
              end
              PH_R_TAIL: begin
                if (bit_r == 3'd7) begin
                  phase_nxt = PH_IDLE;
                  line_nxt  = 1'b1;
                  timer_nxt = '0;
                  bit_nxt   = '0;
                  done      = 1'b1;
                end else begin
                  phase_nxt = PH_R_LOW;
                  line_nxt  = 1'b0;
                  bit_nxt   = bit_r + 3'd1;
                  timer_nxt = load_len(regs.slot_low);
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
                line_nxt  = 1'b1;
                timer_nxt = '0;
                bit_nxt   = '0;
              end
            endcase
          end
        end
      end
      OP_RESET: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          phase_nxt = PH_RST_LOW;
          line_nxt  = 1'b0;
          timer_nxt = load_len(regs.reset_low);
        end
      end
      OP_WRITE: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          shift_nxt = write_byte;
          bit_nxt   = '0;
          phase_nxt = PH_W_LOW;
          line_nxt  = 1'b0;
          timer_nxt = load_len(regs.slot_low);
        end
      end
      OP_READ: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          shift_nxt = '0;
          bit_nxt   = '0;
          phase_nxt = PH_R_LOW;
          line_nxt  = 1'b0;
          timer_nxt = load_len(regs.slot_low);
        end
      end
      default: rej = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b1;
      line_r  <= 1'b1;
    end else if (en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      line_r  <= line_nxt;
    end
  end

  always_comb begin
    res.line_release    = line_nxt;
    res.busy_res        = (phase_nxt != PH_IDLE);
    res.done_res        = done;
    res.presence_absent = pres_nxt;
    res.read_byte       = shift_nxt;
    res.rejected        = rej;
  end

endmodule

[bench/owm_checker.sv]
// Checker: watches the three channels, predicts each result and compares it with the block's.
`timescale 1ns / 100ps
module owm_checker (
  input  logic clk,
  input  logic rst_n,
  owm_in_if    in_mon,
  owm_out_if   out_mon,
  owm_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  import owm_pkg::*;

  localparam int TMR_W = TIMER_WIDTH_DEF;
  localparam logic [31:0] TMR_MAX = 32'((64'd1 << TMR_W) - 64'd1);

  logic [LEN_W-1:0] len_reg [NUM_REGS];
  phase_t           ph;
  logic [TMR_W-1:0] tmr;
  logic [2:0]       bit_idx;
  logic [7:0]       shreg;
  logic             pres_bit;
  logic             line_lvl;

  result_t bus_results_due[$];
  int      n_fail = 0;
  int      n_wait = 0;

  assign fail_count = n_fail;
  assign pending    = n_wait;

  // Zero length counts as one tick; anything past the timer range saturates.
  function automatic void load_phase(phase_t nxt, logic lvl, reg_idx_t idx);
    logic [31:0] v;
    v = 32'(len_reg[idx]);
    if (v == 0) v = 1;
    if (v > TMR_MAX) v = TMR_MAX;
    ph       = nxt;
    line_lvl = lvl;
    tmr      = v[TMR_W-1:0];
  endfunction

  function automatic void drop_to_idle();
    ph       = PH_IDLE;
    line_lvl = 1'b1;
    tmr      = '0;
    bit_idx  = '0;
  endfunction

  // One tick of a running operation; returns 1 when the operation ends.
  function automatic logic tick_phase(logic lin);
    logic b;
    if (ph == PH_RST_REC) begin
      if (lin) begin
        drop_to_idle();
        return 1'b1;
      end
      return 1'b0;
    end
    tmr = tmr - 1'b1;
    if (tmr != 0) return 1'b0;
    case (ph)
      PH_RST_LOW: load_phase(PH_RST_WAIT, 1'b1, REG_PRES_WAIT);
      PH_RST_WAIT: begin
        pres_bit = lin;
        if (lin) begin
          drop_to_idle();
          return 1'b1;
        end
        ph       = PH_RST_REC;
        line_lvl = 1'b1;
        tmr      = '0;
      end
      PH_W_LOW: begin
        b     = shreg[0];
        shreg = shreg >> 1;
        load_phase(PH_W_HOLD, b, REG_WRITE_HOLD);
      end
      PH_W_HOLD: load_phase(PH_W_REC, 1'b1, REG_WRITE_REC);
      PH_W_REC: begin
        if (bit_idx == 3'd7) begin
          drop_to_idle();
          return 1'b1;
        end
        bit_idx = bit_idx + 1'b1;
        load_phase(PH_W_LOW, 1'b0, REG_SLOT_LOW);
      end
      PH_R_LOW: load_phase(PH_R_REL, 1'b1, REG_READ_REL);
      PH_R_REL: begin
        shreg = shreg | ({7'd0, lin} << bit_idx);
        load_phase(PH_R_TAIL, 1'b1, REG_READ_TAIL);
      end
      PH_R_TAIL: begin
        if (bit_idx == 3'd7) begin
          drop_to_idle();
          return 1'b1;
        end
        bit_idx = bit_idx + 1'b1;
        load_phase(PH_R_LOW, 1'b0, REG_SLOT_LOW);
      end
      default: drop_to_idle();
    endcase
    return 1'b0;
  endfunction

  function automatic result_t next_bus_result(op_t op, logic [7:0] wb, logic lin);
    result_t r;
    logic    fin;
    logic    rej;
    fin = 1'b0;
    rej = 1'b0;
    if (op != OP_TICK) begin
      if (ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        case (op)
          OP_RESET: load_phase(PH_RST_LOW, 1'b0, REG_RESET_LOW);
          OP_WRITE: begin
            shreg   = wb;
            bit_idx = '0;
            load_phase(PH_W_LOW, 1'b0, REG_SLOT_LOW);
          end
          default: begin
            shreg   = '0;
            bit_idx = '0;
            load_phase(PH_R_LOW, 1'b0, REG_SLOT_LOW);
          end
        endcase
      end
    end else if (ph != PH_IDLE) begin
      fin = tick_phase(lin);
    end
    r.line_release    = line_lvl;
    r.busy_res        = (ph != PH_IDLE);
    r.done_res        = fin;
    r.presence_absent = pres_bit;
    r.read_byte       = shreg;
    r.rejected        = rej;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      len_reg[REG_RESET_LOW]  = RST_RESET_LOW;
      len_reg[REG_PRES_WAIT]  = RST_PRES_WAIT;
      len_reg[REG_SLOT_LOW]   = RST_SLOT_LOW;
      len_reg[REG_WRITE_HOLD] = RST_WRITE_HOLD;
      len_reg[REG_WRITE_REC]  = RST_WRITE_REC;
      len_reg[REG_READ_REL]   = RST_READ_REL;
      len_reg[REG_READ_TAIL]  = RST_READ_TAIL;
      ph       = PH_IDLE;
      tmr      = '0;
      bit_idx  = '0;
      shreg    = '0;
      pres_bit = 1'b1;
      line_lvl = 1'b1;
      bus_results_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.index < NUM_REGS)
        len_reg[cfg_mon.index] = cfg_mon.data;
      // compare before queueing, so a stray result never meets a fresh prediction
      if (out_mon.valid && out_mon.ready) begin
        if (bus_results_due.size() == 0) begin
          $error("result transaction with nothing outstanding");
          n_fail++;
        end else begin
          want = bus_results_due.pop_front();
          check_field("line_release", 8'(want.line_release), 8'(out_mon.line_release));
          check_field("busy_res", 8'(want.busy_res), 8'(out_mon.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_mon.done_res));
          check_field("presence_absent", 8'(want.presence_absent),
                      8'(out_mon.presence_absent));
          check_field("read_byte", want.read_byte, out_mon.read_byte);
          check_field("rejected", 8'(want.rejected), 8'(out_mon.rejected));
        end
      end
      if (in_mon.valid && in_mon.ready)
        bus_results_due.push_back(next_bus_result(op_t'(in_mon.op), in_mon.write_byte,
                                                  in_mon.line_in));
    end
    n_wait = bus_results_due.size();
  end

endmodule

[bench/tb_one_wire_master_timing_top.sv]
// Testbench top: clock, reset, stimulus and back-pressure for the 1-Wire master timing block.
`timescale 1ns / 100ps
module tb_one_wire_master_timing_top;
  import owm_pkg::*;

  logic clk;
  logic rst_n;

  owm_in_if  in_if ();
  owm_out_if out_if ();
  owm_cfg_if cfg_if ();

  int n_fail;
  int n_pending;

  // Our own copy of the timing registers, used to write them and to size tick runs.
  logic [LEN_W-1:0] timing [NUM_REGS];

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int items_sent = 0;

  one_wire_master_timing_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  owm_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (n_fail),
    .pending    (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly no gap, some short ones, the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side back-pressure; changes only at the falling edge.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        if (stalls_on && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  // One input transaction. Entered and left at a falling edge; valid stays
  // high on exit so back-to-back transactions never drop it in between.
  task automatic send_item(op_t op, logic [7:0] wb, logic lin);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.op         = op;
    in_if.write_byte = wb;
    in_if.line_in    = lin;
    in_if.valid      = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic tick_run(int n);
    for (int k = 0; k < n; k++)
      send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Sender pauses until every predicted result has come back; the callers then
  // write the registers, though the block need not be idle by then.
  task automatic drain();
    in_if.valid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_timing();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_if.index = reg_idx_t'(i);
      cfg_if.data  = timing[i];
      cfg_if.valid = 1'b1;
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_if.valid = 1'b0;
    repeat (2) @(negedge clk);
  endtask

  function automatic int eff_len(reg_idx_t r);
    return (timing[r] == 0) ? 1 : int'(timing[r]);
  endfunction

  // Rough tick count for a whole operation at the current settings.
  function automatic int op_ticks(op_t op);
    case (op)
      OP_RESET: return eff_len(REG_RESET_LOW) + eff_len(REG_PRES_WAIT);
      OP_WRITE: return BYTE_W * (eff_len(REG_SLOT_LOW) + eff_len(REG_WRITE_HOLD) +
                                 eff_len(REG_WRITE_REC));
      default:  return BYTE_W * (eff_len(REG_SLOT_LOW) + eff_len(REG_READ_REL) +
                                 eff_len(REG_READ_TAIL));
    endcase
  endfunction

  // Well-formed operation: command, then roughly enough ticks to finish it,
  // random line levels throughout, now and then a command that lands while busy.
  task automatic run_op(op_t op, logic [7:0] wb);
    int n;
    n = op_ticks(op) + $urandom_range(0, 4);
    send_item(op, wb, 1'($urandom_range(0, 1)));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0)
        send_item(op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Random settings: mostly very short phases so operations stay cheap.
  function automatic logic [LEN_W-1:0] pick_len(bit wide);
    int r;
    if (wide) return LEN_W'($urandom_range(4, 12));
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 9) return LEN_W'($urandom_range(1, 3));
    return LEN_W'($urandom_range(4, 8));
  endfunction

  initial begin
    int budget;
    int r;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_TICK;
    in_if.write_byte = '0;
    in_if.line_in    = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_RESET_LOW;
    cfg_if.data      = '0;
    timing[REG_RESET_LOW]  = RST_RESET_LOW;
    timing[REG_PRES_WAIT]  = RST_PRES_WAIT;
    timing[REG_SLOT_LOW]   = RST_SLOT_LOW;
    timing[REG_WRITE_HOLD] = RST_WRITE_HOLD;
    timing[REG_WRITE_REC]  = RST_WRITE_REC;
    timing[REG_READ_REL]   = RST_READ_REL;
    timing[REG_READ_TAIL]  = RST_READ_TAIL;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset values of the timing registers: one byte read untouched.
    run_op(OP_READ, 8'h5A);

    // Directed: every length zero, so each phase is a single tick.
    drain();
    for (int i = 0; i < NUM_REGS; i++) timing[i] = '0;
    write_timing();
    send_item(OP_TICK, 8'h00, 1'b0);     // tick while idle: nothing moves
    send_item(OP_TICK, 8'hFF, 1'b1);
    send_item(OP_RESET, 8'h00, 1'b0);
    send_item(OP_TICK, 8'h00, 1'b0);     // low pulse over, presence wait
    send_item(OP_READ, 8'hFF, 1'b1);     // command while busy: rejected, no tick
    send_item(OP_TICK, 8'h00, 1'b0);     // device answers: line low at sample
    send_item(OP_TICK, 8'h00, 1'b0);     // still held low, keep waiting
    send_item(OP_TICK, 8'h00, 1'b1);     // line back high, reset done
    send_item(OP_RESET, 8'hFF, 1'b1);
    send_item(OP_TICK, 8'h00, 1'b1);
    send_item(OP_TICK, 8'h00, 1'b1);     // no device: done on the sampling tick
    send_item(OP_WRITE, 8'hFF, 1'b0);
    tick_run(12);
    send_item(OP_WRITE, 8'h00, 1'b1);    // rejected mid-byte
    tick_run(12);
    send_item(OP_WRITE, 8'h00, 1'b0);
    tick_run(24);
    send_item(OP_READ, 8'h00, 1'b0);
    tick_run(24);

    // Random part: several settings, each drained before its registers change.
    for (int round = 0; round < 5; round++) begin
      drain();
      for (int i = 0; i < NUM_REGS; i++) timing[i] = pick_len(round == 4);
      write_timing();
      // an occasional stretch with no idling at all
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      budget    = items_sent + 100;
      while (items_sent < budget) begin
        r = $urandom_range(0, 99);
        if (r < 88)
          run_op(op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        else
          tick_run($urandom_range(1, 4));
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    drain();
    if (n_fail == 0 && n_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
